// ===== hdl/btlm_pkg.sv =====
// Shared constants and types for the bakery ticket lock manager.
package btlm_pkg;

	localparam int STATUS_W = 3;
	localparam int SLOT_OUT_W = 3;
	localparam int TICKET_OUT_W = 16;
	localparam int PID_IN_W = 16;
	localparam int OUT_DATA_W = 48;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_QUEUED    = 3'd0;
	localparam status_t ST_FULL      = 3'd1;
	localparam status_t ST_RELEASED  = 3'd2;
	localparam status_t ST_NOTFOUND  = 3'd3;
	localparam status_t ST_SATURATED = 3'd4;

	localparam logic MODE_ACQUIRE = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

endpackage

// ===== hdl/btlm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module btlm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/btlm_modsc.sv =====
// Remainder of a process id by the slot count, by reciprocal multiplication.
module btlm_modsc #(
	parameter int PID_WIDTH = 16,
	parameter int SLOTS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [PID_WIDTH-1:0]     dividend,
	output logic                     done,
	output logic [$clog2(SLOTS)-1:0] rem
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int SHIFT = PID_WIDTH + SLOT_W;
	localparam int PROD_W = SHIFT + PID_WIDTH;
	localparam int DIFF_W = PID_WIDTH + SLOT_W;
	localparam logic [63:0] ONE = 64'd1;
	// Rounded-up reciprocal with SLOT_W extra bits of precision, which makes the
	// quotient exact for every dividend of PID_WIDTH bits.
	localparam logic [63:0] RECIP_FULL = ((ONE << SHIFT) + 64'(SLOTS) - ONE) / 64'(SLOTS);
	localparam logic [PID_WIDTH:0] RECIP = RECIP_FULL[PID_WIDTH:0];
	localparam logic [DIFF_W-1:0] DIVISOR = DIFF_W'(SLOTS);

	logic [PID_WIDTH-1:0] x_s1;
	logic                 v_s1;
	logic [PID_WIDTH-1:0] x_s2;
	logic [PID_WIDTH-1:0] quo_s2;
	logic                 v_s2;
	logic [SLOT_W-1:0]    rem_q;
	logic                 done_q;
	logic [PROD_W-1:0]    prod;
	logic [DIFF_W-1:0]    diff;

	always_comb begin
		prod = PROD_W'(x_s1) * PROD_W'(RECIP);
		// The true difference is below SLOTS, so its low bits survive the wrap.
		diff = DIFF_W'(x_s2) - DIFF_W'(quo_s2) * DIVISOR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			if (start) begin
				done_q <= 1'b0;
			end else if (v_s2) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_s1 <= dividend;
		end
		if (v_s1) begin
			x_s2   <= x_s1;
			quo_s2 <= prod[SHIFT +: PID_WIDTH];
		end
		if (v_s2) begin
			rem_q <= diff[SLOT_W-1:0];
		end
	end

	assign done = done_q;
	assign rem = rem_q;

endmodule

// ===== hdl/bakery_ticket_lock_manager.sv =====
// Bakery ticket lock manager: request sequencer around the slot table RAM.
//
// Requests arrive on the s_ channel: s_tuser is the mode (0 acquire,
// 1 release) and s_tdata the process id. Each transaction gives exactly one
// result transaction on the m_ channel carrying the status, the slot taken
// or freed, the ticket granted and the current lock holder.
// Owners and tickets live in one RAM of SLOTS words; the used flags are
// flip-flops. A request walks the RAM once to find a free slot, the largest
// held ticket or the matching owner, writes the table, then walks it again
// to find the holder (lowest ticket, then lowest slot).
// An acquire first forms pid modulo SLOTS by reciprocal multiplication.
// One request is in progress at a time and the next is accepted in the
// cycle after the result is loaded into the output register.
// A finished result sits in the output register, and the next request is
// accepted while it waits; if the receiver stalls, the following result
// holds in the sequencer until the output register frees.
// Reset marks every slot free and empties the output register.
module bakery_ticket_lock_manager
	import btlm_pkg::*;
#(
	parameter int SLOTS = 8,
	parameter int PID_WIDTH = 16,
	parameter int TICKET_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PID_IN_W-1:0]   s_tdata,  // [15:0] pid
	input  logic                  s_tuser,  // [0] mode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [2:0] status, [5:3] slot, [21:6] ticket, [22] holder_valid,
	// [25:23] holder_slot, [41:26] holder_pid, [47:42] zero
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int WORD_W = PID_WIDTH + TICKET_WIDTH;
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOTS);
	localparam logic [TICKET_WIDTH-1:0] TKT_MAX = '1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_SCAN,
		S_APPLY,
		S_HOLD,
		S_DONE
	} state_t;

	state_t state_q;

	logic                    mode_q;
	logic [PID_WIDTH-1:0]    pid_q;
	logic [SLOTS-1:0]        used_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    rd_v_q;
	logic [SLOT_W-1:0]       rd_idx_q;
	logic                    free_found_q;
	logic [SLOT_W-1:0]       free_idx_q;
	logic                    match_found_q;
	logic [SLOT_W-1:0]       match_idx_q;
	logic [TICKET_WIDTH-1:0] top_q;
	status_t                 status_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [TICKET_WIDTH-1:0] ticket_q;
	logic                    hv_q;
	logic [SLOT_W-1:0]       hs_q;
	logic [PID_WIDTH-1:0]    hp_q;
	logic [TICKET_WIDTH-1:0] best_q;
	logic                    m_tvalid_q;
	logic [OUT_DATA_W-1:0]   m_tdata_q;

	logic [PID_WIDTH+PID_IN_W-1:0] pid_ext;
	logic [PID_WIDTH-1:0]          pid_in;
	logic                          mod_done;
	logic [SLOT_W-1:0]             home;
	logic                          accept;
	logic                          scanning;
	logic [SLOT_W-1:0]             scan_idx;
	logic                          ram_we;
	logic [SLOT_W-1:0]             ram_waddr;
	logic [WORD_W-1:0]             ram_wdata;
	logic [WORD_W-1:0]             ram_rdata;
	logic [PID_WIDTH-1:0]          rd_owner;
	logic [TICKET_WIDTH-1:0]       rd_tkt;
	logic                          home_used;
	logic                          acq_ok;
	logic [SLOT_W-1:0]             acq_slot;
	logic [TICKET_WIDTH-1:0]       new_tkt;
	logic                          load_out;
	logic [SLOT_W+SLOT_OUT_W-1:0]  slot_ext;
	logic [SLOT_W+SLOT_OUT_W-1:0]  hs_ext;
	logic [TICKET_WIDTH+TICKET_OUT_W-1:0] tkt_ext;
	logic [PID_WIDTH+PID_IN_W-1:0] hp_ext;

	assign pid_ext = {{PID_WIDTH{1'b0}}, s_tdata};
	assign pid_in = pid_ext[PID_WIDTH-1:0];
	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);

	btlm_modsc #(
		.PID_WIDTH(PID_WIDTH),
		.SLOTS(SLOTS)
	) u_modsc (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept && (s_tuser == MODE_ACQUIRE)),
		.dividend(pid_in),
		.done(mod_done),
		.rem(home)
	);

	assign scanning = ((state_q == S_SCAN) || (state_q == S_HOLD)) && (cnt_q < CNT_END);
	assign scan_idx = cnt_q[SLOT_W-1:0];

	btlm_ram #(
		.WIDTH(WORD_W),
		.DEPTH(SLOTS)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(scan_idx),
		.rdata(ram_rdata)
	);

	assign rd_owner = ram_rdata[WORD_W-1:TICKET_WIDTH];
	assign rd_tkt = ram_rdata[TICKET_WIDTH-1:0];

	always_comb begin
		home_used = used_q[home];
		acq_ok = !home_used || free_found_q;
		acq_slot = home_used ? free_idx_q : home;
		new_tkt = (top_q == TKT_MAX) ? TKT_MAX : top_q + 1'b1;
		ram_we = (state_q == S_APPLY) && (mode_q == MODE_ACQUIRE) && acq_ok;
		ram_waddr = acq_slot;
		ram_wdata = {pid_q, new_tkt};
	end

	assign load_out = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	assign slot_ext = {{SLOT_OUT_W{1'b0}}, slot_q};
	assign hs_ext = {{SLOT_OUT_W{1'b0}}, hs_q};
	assign tkt_ext = {{TICKET_OUT_W{1'b0}}, ticket_q};
	assign hp_ext = {{PID_IN_W{1'b0}}, hp_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			used_q        <= '0;
			cnt_q         <= '0;
			rd_v_q        <= 1'b0;
			free_found_q  <= 1'b0;
			match_found_q <= 1'b0;
			hv_q          <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			rd_v_q   <= scanning;
			rd_idx_q <= scan_idx;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q        <= s_tuser;
						pid_q         <= pid_in;
						cnt_q         <= '0;
						free_found_q  <= 1'b0;
						match_found_q <= 1'b0;
						top_q         <= '0;
						state_q       <= (s_tuser == MODE_ACQUIRE) ? S_MOD : S_SCAN;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scanning) begin
						cnt_q <= cnt_q + 1'b1;
						if (!used_q[scan_idx] && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= scan_idx;
						end
					end
					// RAM data arrives in the cycle after its address is presented.
					if (rd_v_q && used_q[rd_idx_q]) begin
						if (rd_tkt > top_q) begin
							top_q <= rd_tkt;
						end
						if (rd_owner == pid_q && !match_found_q) begin
							match_found_q <= 1'b1;
							match_idx_q   <= rd_idx_q;
						end
					end
					if (!scanning && !rd_v_q) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (mode_q == MODE_ACQUIRE) begin
						if (acq_ok) begin
							used_q[acq_slot] <= 1'b1;
							slot_q   <= acq_slot;
							ticket_q <= new_tkt;
							status_q <= (top_q == TKT_MAX) ? ST_SATURATED : ST_QUEUED;
						end else begin
							slot_q   <= '0;
							ticket_q <= '0;
							status_q <= ST_FULL;
						end
					end else if (match_found_q) begin
						used_q[match_idx_q] <= 1'b0;
						slot_q   <= match_idx_q;
						ticket_q <= '0;
						status_q <= ST_RELEASED;
					end else begin
						slot_q   <= '0;
						ticket_q <= '0;
						status_q <= ST_NOTFOUND;
					end
					cnt_q   <= '0;
					hv_q    <= 1'b0;
					hs_q    <= '0;
					hp_q    <= '0;
					best_q  <= '0;
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (scanning) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (rd_v_q && used_q[rd_idx_q] && (!hv_q || rd_tkt < best_q)) begin
						hv_q   <= 1'b1;
						best_q <= rd_tkt;
						hs_q   <= rd_idx_q;
						hp_q   <= rd_owner;
					end
					if (!scanning && !rd_v_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {6'b0, hp_ext[PID_IN_W-1:0], hs_ext[SLOT_OUT_W-1:0], hv_q,
				tkt_ext[TICKET_OUT_W-1:0], slot_ext[SLOT_OUT_W-1:0], status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule
